[hw/rtl/zsad_pkg.sv]
// ----------------------------------------------------------------------------
// zsad_pkg: shared types and constants of the rolling z-score detector
// Holds the controller-to-datapath command struct and the fixed constants
// of the threshold test.
// ----------------------------------------------------------------------------
package zsad_pkg;

  // Step commands from the controller, at most one active per cycle.
  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
    logic step3;
    logic finish;
  } zsad_cmd_t;

  localparam int unsigned SIGMA_BITS  = 8;
  localparam int unsigned KSQ_BITS    = 2 * SIGMA_BITS;
  localparam logic [SIGMA_BITS-1:0] SIGMA_RESET = 8'd40;

  // The Q4.4 factor squared carries eight fraction bits, so the left side
  // of the test is scaled by 256.
  localparam int unsigned LHS_SHIFT = 8;

endpackage

[hw/rtl/zsad_ctrl.sv]
// ----------------------------------------------------------------------------
// zsad_ctrl: sequencing controller
// Walks each accepted item through the load, three arithmetic steps and the
// finish step, and owns the output valid flag.
// ----------------------------------------------------------------------------
module zsad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output zsad_pkg::zsad_cmd_t cmd_o
);
  import zsad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP1,
    ST_STEP2,
    ST_STEP3,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   finish_ok;

  // The result register can take a new result when it is empty or being drained.
  assign finish_ok   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.step1  = (state_q == ST_STEP1);
    cmd_o.step2  = (state_q == ST_STEP2);
    cmd_o.step3  = (state_q == ST_STEP3);
    cmd_o.finish = (state_q == ST_FINISH) && finish_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new result replaces the one that drains in the same cycle.
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_STEP1;
          end
        end
        ST_STEP1: state_q <= ST_STEP2;
        ST_STEP2: state_q <= ST_STEP3;
        ST_STEP3: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (finish_ok) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/zsad_lane.sv]
// ----------------------------------------------------------------------------
// zsad_lane: one channel's running statistics and threshold test
// Keeps the running sum and sum of squares of the window and evaluates
// 256*(N*x-S)^2 > k^2*(N*SS-S^2) over three registered steps.
// ----------------------------------------------------------------------------
module zsad_lane #(
  parameter int unsigned WINDOW_DEPTH = 20,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  zsad_pkg::zsad_cmd_t                 cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       old_i,
  input  logic [zsad_pkg::KSQ_BITS-1:0]       ksq_i,
  input  logic                                filled_i,
  output logic                                alert_o
);
  import zsad_pkg::*;

  localparam int unsigned NW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW  = SAMPLE_BITS + NW;       // running sum
  localparam int unsigned PW  = 2 * SAMPLE_BITS;        // one square
  localparam int unsigned SSW = 2 * SAMPLE_BITS + NW;   // running square sum
  localparam int unsigned VW  = 2 * SW;                 // N*SS, S^2, variance
  localparam int unsigned DW  = SW + 1;                 // N*x - S
  localparam int unsigned VH  = (VW + 1) / 2;           // low half of variance
  localparam int unsigned VU  = VW - VH;                // high half of variance
  localparam int unsigned CW  = VW + KSQ_BITS;          // compare width

  localparam logic signed [DW-1:0] N_D = DW'(WINDOW_DEPTH);
  localparam logic [VW-1:0]        N_V = VW'(WINDOW_DEPTH);

  logic signed [SW-1:0]  sum_q, sum_d;
  logic [SSW-1:0]        sqsum_q, sqsum_d;

  logic signed [DW-1:0]  dev_q, dev_d;
  logic [VW-1:0]         nss_q, nss_d;
  logic [VW-1:0]         ssq_q, ssq_d;
  logic [PW-1:0]         xsq_q, oldsq_q;
  logic signed [PW-1:0]  xsq_s, oldsq_s;
  logic [VW-1:0]         var_q, var_d;
  logic [VW-1:0]         dsq_q, dsq_d;
  logic [VU+KSQ_BITS-1:0] pph_q, pph_d;
  logic [VH+KSQ_BITS-1:0] ppl_q, ppl_d;
  logic                  nz_q;
  logic [SW-1:0]         sum_mag;
  logic [DW-1:0]         dev_mag;
  logic [CW-1:0]         lhs, rhs;

  // Step 1: deviation from the window, N*SS, S^2 and the two squares.
  assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign dev_d   = N_D * DW'(sample_i) - DW'(sum_q);
  assign nss_d   = VW'(sqsum_q) * N_V;
  assign ssq_d   = VW'(sum_mag) * VW'(sum_mag);
  assign xsq_s   = PW'(sample_i) * PW'(sample_i);
  assign oldsq_s = PW'(old_i) * PW'(old_i);
  assign sum_d   = sum_q + SW'(sample_i) - SW'(old_i);

  // Step 2: variance term and the squared deviation.
  assign dev_mag = dev_q[DW-1] ? DW'(-dev_q) : DW'(dev_q);
  assign var_d   = nss_q - ssq_q;
  assign dsq_d   = VW'(dev_mag) * VW'(dev_mag);
  assign sqsum_d = sqsum_q + SSW'(xsq_q) - SSW'(oldsq_q);

  // Step 3: k^2 times the variance, split in two narrow partial products.
  assign ppl_d = (VH + KSQ_BITS)'(var_q[VH-1:0]) * (VH + KSQ_BITS)'(ksq_i);
  assign pph_d = (VU + KSQ_BITS)'(var_q[VW-1:VH]) * (VU + KSQ_BITS)'(ksq_i);

  // Finish: strict compare of the scaled deviation against the threshold.
  assign rhs     = (CW'(pph_q) << VH) + CW'(ppl_q);
  assign lhs     = CW'(dsq_q) << LHS_SHIFT;
  assign alert_o = filled_i && nz_q && (lhs > rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sqsum_q <= '0;
    end else begin
      if (cmd_i.step1) begin
        sum_q <= sum_d;
      end
      if (cmd_i.step2) begin
        sqsum_q <= sqsum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step1) begin
      dev_q   <= dev_d;
      nss_q   <= nss_d;
      ssq_q   <= ssq_d;
      xsq_q   <= $unsigned(xsq_s);
      oldsq_q <= $unsigned(oldsq_s);
    end
    if (cmd_i.step2) begin
      var_q <= var_d;
      dsq_q <= dsq_d;
    end
    if (cmd_i.step3) begin
      ppl_q <= ppl_d;
      pph_q <= pph_d;
      nz_q  <= |var_q;
    end
  end

endmodule

[hw/rtl/zsad_dpath.sv]
// ----------------------------------------------------------------------------
// zsad_dpath: detector datapath
// Holds the sample ring memory, write position, fill flag, threshold
// register, the three channel lanes and the result register.
// ----------------------------------------------------------------------------
module zsad_dpath #(
  parameter int unsigned WINDOW_DEPTH = 20,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned OUT_W        = 56
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  zsad_pkg::zsad_cmd_t               cmd_i,
  input  logic [3*SAMPLE_BITS-1:0]          in_data_i,
  input  logic                              cfg_we_i,
  input  logic [zsad_pkg::SIGMA_BITS-1:0]   cfg_wdata_i,
  output logic [OUT_W-1:0]                  out_data_o
);
  import zsad_pkg::*;

  localparam int unsigned XW = 3 * SAMPLE_BITS;
  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_DEPTH - 1);

  logic [XW-1:0]         ring_mem [WINDOW_DEPTH];
  logic [XW-1:0]         x_q;
  logic [XW-1:0]         old_q;
  logic [XW-1:0]         old_v;
  logic [AW-1:0]         pos_q;
  logic                  filled_q;
  logic [SIGMA_BITS-1:0] sigma_q;
  logic [KSQ_BITS-1:0]   ksq_q;
  logic [OUT_W-1:0]      out_q;
  logic [2:0]            alert;

  // Before the first wrap the entry at the write position was never written,
  // so it is read as zero, matching the sums that reset cleared.
  assign old_v = filled_q ? old_q : '0;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    zsad_lane #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd_i),
      .sample_i ($signed(x_q[c*SAMPLE_BITS +: SAMPLE_BITS])),
      .old_i    ($signed(old_v[c*SAMPLE_BITS +: SAMPLE_BITS])),
      .ksq_i    (ksq_q),
      .filled_i (filled_q),
      .alert_o  (alert[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= in_data_i;
      old_q <= ring_mem[pos_q];
      ksq_q <= KSQ_BITS'(sigma_q) * KSQ_BITS'(sigma_q);
    end
    if (cmd_i.step1) begin
      ring_mem[pos_q] <= x_q;
    end
    if (cmd_i.finish) begin
      out_q <= OUT_W'({|alert, alert, x_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      filled_q <= 1'b0;
      sigma_q  <= SIGMA_RESET;
    end else begin
      if (cfg_we_i) begin
        sigma_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        if (pos_q == LAST_POS) begin
          pos_q    <= '0;
          filled_q <= 1'b1;
        end else begin
          pos_q <= pos_q + AW'(1);
        end
      end
    end
  end

  assign out_data_o = out_q;

endmodule

[hw/rtl/rolling_zscore_anomaly_detector.sv]
// ----------------------------------------------------------------------------
// rolling_zscore_anomaly_detector: sliding-window z-score outlier detector
// Flags temperature, vibration and current samples that stand more than
// k standard deviations from the mean of their last WINDOW_DEPTH samples.
// ----------------------------------------------------------------------------
// Usage: one sample triple is taken per transfer on the slave stream and
// exactly one result per triple leaves on the master stream. The result
// echoes the three samples with one alert bit per channel and their OR.
// The threshold k (unsigned Q4.4) is written through cfg_we_i/cfg_wdata_i
// while the block is idle; it resets to 2.5.
// After the input transfer the controller passes through STEP1, STEP2, STEP3
// and FINISH, and m_axis_tvalid is registered as FINISH completes. Each triple passes through
// a load cycle and four steps of the per-channel lanes (squares, variance,
// threshold product, compare), so a new triple is taken only after the last
// one finishes; s_axis_tready is high only between items.
// Reset clears the sums, the write position and the fill flag; the window
// then counts as all zeros and no alert is raised until it has wrapped.
// When the receiver stalls, the result register holds its transfer and the
// block computes the next triple, then waits until the register drains.
// ----------------------------------------------------------------------------
module rolling_zscore_anomaly_detector #(
  parameter int unsigned WINDOW_DEPTH = 20,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // temperature_sample, vibration_sample, current_sample
  input  logic [((3 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // temperature_echo, vibration_echo, current_echo, temperature_alert,
  // vibration_alert, current_alert, anomaly
  output logic [((3 * SAMPLE_BITS + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [zsad_pkg::SIGMA_BITS-1:0] cfg_wdata_i
);
  import zsad_pkg::*;

  localparam int unsigned XW    = 3 * SAMPLE_BITS;
  localparam int unsigned OUT_W = ((3 * SAMPLE_BITS + 4 + 7) / 8) * 8;

  zsad_cmd_t cmd;

  zsad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  zsad_dpath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .OUT_W        (OUT_W)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata[XW-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTH
  // Only one item is in flight: the input closes right after a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // A fresh result appears only after its input transfer has passed STEP1, STEP2, STEP3 and FINISH.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 5))
    else $error("result valid without matching input transfer");

  // The anomaly flag is the OR of the three channel alerts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[XW+3] == (|m_axis_tdata[XW+2:XW])))
    else $error("anomaly flag disagrees with channel alerts");
`endif

endmodule
